### sv/nwum_pkg.sv
// Shared types and constants for the momentum weight update block.
// Depends on nothing; nwum_delta and the top level import it.
package nwum_pkg;

	// Q4.12 values, Q0.16 factors.
	localparam int VAL_W     = 16;
	localparam int FRAC_W    = 12;
	localparam int CFG_W     = 16;
	localparam int CLIP_W    = 15;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [VAL_W-1:0] val_t;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RECUR_EN   = 3'd4;

	// Register values after reset.
	localparam logic [CFG_W-1:0]  RST_LEARN_RATE = 16'd9830;
	localparam logic [CFG_W-1:0]  RST_MOMENTUM   = 16'd32768;
	localparam logic [CLIP_W-1:0] RST_CLIP_LIMIT = 15'd4096;

	// Input action codes.
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	// What a word does once it is in the pipeline.
	typedef logic [1:0] op_t;
	localparam op_t OP_NONE = 2'd0;  // slot out of range: zero result, skipped
	localparam op_t OP_LOAD = 2'd1;  // write weight, clear delta
	localparam op_t OP_UPD  = 2'd2;  // momentum update
	localparam op_t OP_HOLD = 2'd3;  // dropped source or recurrency off: skipped

	typedef struct packed {
		logic valid;
		op_t  op;
	} ctl_t;

endpackage

### sv/nwum_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nwum_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/nwum_delta.sv
// Three-stage datapath that forms the new delta, eta*act*grad + alpha*old_delta,
// rounded half up to Q4.12 and saturated. Depends on nwum_pkg.
module nwum_delta (
	input  logic                     clk,
	input  logic [nwum_pkg::CFG_W-1:0] learn_rate,
	input  logic [nwum_pkg::CFG_W-1:0] momentum,
	input  nwum_pkg::val_t           act_s2,
	input  nwum_pkg::val_t           grad_s2,
	input  nwum_pkg::val_t           old_d_s2,
	output nwum_pkg::val_t           delta_s5,
	output logic                     dsat_s5
);
	import nwum_pkg::*;

	localparam int AG_W   = 2 * VAL_W;          // act * grad, Q8.24
	localparam int PD_W   = 2 * VAL_W;          // old_delta * alpha, Q4.28
	localparam int ETA_W  = 3 * VAL_W;          // act * grad * eta, Q8.40
	localparam int ACC_W  = ETA_W + 1;
	localparam int RND_SH = CFG_W + FRAC_W;     // Q8.40 down to Q4.12
	localparam int RW     = ACC_W - RND_SH;

	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (RND_SH - 1);
	localparam logic signed [RW-1:0]    R_MAX    = RW'((1 << (VAL_W - 1)) - 1);
	localparam logic signed [RW-1:0]    R_MIN    = RW'(-(1 << (VAL_W - 1)));

	logic signed [AG_W-1:0]  p_ag_c, p_ag_s3;
	logic signed [PD_W-1:0]  pd_full;
	logic signed [PD_W-1:0]  pd_s3, pd_s4;
	logic signed [ETA_W-1:0] p_eta_c, p_eta_s4;
	logic signed [ACC_W-1:0] acc;
	logic signed [RW-1:0]    rounded;
	val_t                    delta_c;
	logic                    dsat_c;

	// Stage 2: the two narrow products. Both fit their widths exactly.
	always_comb begin
		p_ag_c  = AG_W'(act_s2) * AG_W'(grad_s2);
		pd_full = PD_W'(old_d_s2) * PD_W'($signed({1'b0, momentum}));
	end

	// Stage 3: scale by the learning rate.
	always_comb begin
		p_eta_c = ETA_W'(p_ag_s3) * ETA_W'($signed({1'b0, learn_rate}));
	end

	// Stage 4: align, sum, round half up, saturate.
	always_comb begin
		acc     = ACC_W'(p_eta_s4) + (ACC_W'(pd_s4) <<< FRAC_W) + RND_HALF;
		rounded = RW'(acc >>> RND_SH);
		dsat_c  = 1'b0;
		if (rounded > R_MAX) begin
			delta_c = val_t'(R_MAX);
			dsat_c  = 1'b1;
		end else if (rounded < R_MIN) begin
			delta_c = val_t'(R_MIN);
			dsat_c  = 1'b1;
		end else begin
			delta_c = val_t'(rounded);
		end
	end

	always_ff @(posedge clk) begin
		p_ag_s3  <= p_ag_c;
		pd_s3    <= pd_full;
		p_eta_s4 <= p_eta_c;
		pd_s4    <= pd_s3;
		delta_s5 <= delta_c;
		dsat_s5  <= dsat_c;
	end

endmodule

### sv/neuron_weight_update_momentum.sv
// Top level of the momentum weight update block: issue stage, weight memory,
// slot interlock, weight saturation and result register. Depends on nwum_pkg,
// nwum_ram and nwum_delta.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+------------------------
//  item in  | action slot activation gradient source_alive       | start & !busy
//           | load_value                                         |
//  result   | new_weight new_delta skipped saturated             | done, one cycle, no stall
//  config   | cfg_index cfg_data                                 | cfg_we, no wait
//
// One word is taken per cycle as long as its slot differs from the slots of the
// writing words still in the five stages behind the input. A word aimed at a
// slot with a write in flight sees busy over the distance from the memory read
// at acceptance to the write-back in the last stage. Reset clears the valid
// bits, the result strobe and the configuration registers; the weight memory is
// not cleared, so a slot must be loaded before it is updated. The receiver takes
// every result as it comes.
module neuron_weight_update_momentum #(
	parameter  int MAX_INPUTS = 64,
	localparam int SLOT_W     = $clog2(MAX_INPUTS + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item in
	input  logic                           start,
	output logic                           busy,
	input  logic                           action,
	input  logic [SLOT_W-1:0]              slot,
	input  nwum_pkg::val_t                 activation,
	input  nwum_pkg::val_t                 gradient,
	input  logic                           source_alive,
	input  nwum_pkg::val_t                 load_value,
	// result
	output logic                           done,
	output nwum_pkg::val_t                 new_weight,
	output nwum_pkg::val_t                 new_delta,
	output logic                           skipped,
	output logic                           saturated,
	// configuration
	input  logic                           cfg_we,
	input  logic [nwum_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nwum_pkg::CFG_W-1:0]     cfg_data
);
	import nwum_pkg::*;

	localparam int DEPTH = MAX_INPUTS + 1;   // ordinary slots plus the recurrent slot
	localparam logic [SLOT_W-1:0] RECUR_SLOT = SLOT_W'(MAX_INPUTS);

	localparam logic signed [VAL_W:0] W_MAX = (VAL_W+1)'((1 << (VAL_W - 1)) - 1);
	localparam logic signed [VAL_W:0] W_MIN = (VAL_W+1)'(-(1 << (VAL_W - 1)));

	// True when a stage holds a word that will write the given slot.
	function automatic logic writes_slot(ctl_t c, logic [SLOT_W-1:0] a,
			logic [SLOT_W-1:0] b);
		return c.valid && (c.op == OP_LOAD || c.op == OP_UPD) && (a == b);
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0]  learn_rate_q;
	logic [CFG_W-1:0]  momentum_q;
	logic              clip_en_q;
	logic [CLIP_W-1:0] clip_limit_q;
	logic              recur_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= RST_LEARN_RATE;
			momentum_q   <= RST_MOMENTUM;
			clip_en_q    <= 1'b0;
			clip_limit_q <= RST_CLIP_LIMIT;
			recur_en_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEARN_RATE: learn_rate_q <= cfg_data;
				REG_MOMENTUM:   momentum_q   <= cfg_data;
				REG_CLIP_EN:    clip_en_q    <= cfg_data[0];
				REG_CLIP_LIMIT: clip_limit_q <= cfg_data[CLIP_W-1:0];
				REG_RECUR_EN:   recur_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline registers. Control carries a valid bit; slot and data travel with it.
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [SLOT_W-1:0] slot_s1, slot_s2, slot_s3, slot_s4, slot_s5;
	val_t              act_s1, grad_s1, load_s1;
	val_t              act_s2, gclip_s2;
	val_t              old_w_s2, old_w_s3, old_w_s4, old_w_s5;
	val_t              old_d_s2, old_d_s3, old_d_s4, old_d_s5;
	val_t              delta_s5;
	logic              dsat_s5;

	logic              accept;
	op_t               op_in;
	logic              run_in;
	logic [2*VAL_W-1:0] rd_word;
	val_t              rd_w, rd_d;
	val_t              gclip_c, old_w_c, old_d_c;
	logic signed [VAL_W:0] g_ext, lim_ext;

	// Interlock: a word may not read a slot whose new value is still on its way
	// to the memory. The write lands at the edge that ends the fifth stage.
	always_comb begin
		busy = writes_slot(ctl_s1, slot_s1, slot) || writes_slot(ctl_s2, slot_s2, slot) ||
		       writes_slot(ctl_s3, slot_s3, slot) || writes_slot(ctl_s4, slot_s4, slot) ||
		       writes_slot(ctl_s5, slot_s5, slot);
	end

	assign accept = start && !busy;

	// Decode the word at the input. The recurrent slot ignores source_alive.
	always_comb begin
		run_in = (slot == RECUR_SLOT) ? recur_en_q : source_alive;
		if (slot > RECUR_SLOT) begin
			op_in = OP_NONE;
		end else if (action == ACT_LOAD) begin
			op_in = OP_LOAD;
		end else if (run_in) begin
			op_in = OP_UPD;
		end else begin
			op_in = OP_HOLD;
		end
	end

	// Each entry holds the weight in the upper half and the delta in the lower.
	logic               ram_we;
	logic [2*VAL_W-1:0] ram_wdata;
	val_t               w_fin, d_fin;

	nwum_ram #(
		.WIDTH (2 * VAL_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_s5),
		.wdata (ram_wdata),
		.raddr (slot),
		.rdata (rd_word)
	);

	assign rd_w = rd_word[2*VAL_W-1:VAL_W];
	assign rd_d = rd_word[VAL_W-1:0];

	// Stage 1: the stored values arrive; clip the gradient. A load replaces the
	// old values with the loaded weight and a zero delta, an out-of-range word
	// with zeros, so the last stage only has to pass them on.
	always_comb begin
		g_ext   = {grad_s1[VAL_W-1], grad_s1};
		lim_ext = $signed((VAL_W+1)'(clip_limit_q));
		gclip_c = grad_s1;
		if (clip_en_q) begin
			if (g_ext > lim_ext) begin
				gclip_c = val_t'(lim_ext);
			end else if (g_ext < -lim_ext) begin
				gclip_c = val_t'(-lim_ext);
			end
		end
		case (ctl_s1.op)
			OP_LOAD: begin
				old_w_c = load_s1;
				old_d_c = '0;
			end
			OP_NONE: begin
				old_w_c = '0;
				old_d_c = '0;
			end
			default: begin
				old_w_c = rd_w;
				old_d_c = rd_d;
			end
		endcase
	end

	// Stages 2 to 4 live in the delta datapath; old values ride alongside.
	nwum_delta u_delta (
		.clk        (clk),
		.learn_rate (learn_rate_q),
		.momentum   (momentum_q),
		.act_s2     (act_s2),
		.grad_s2    (gclip_s2),
		.old_d_s2   (old_d_s2),
		.delta_s5   (delta_s5),
		.dsat_s5    (dsat_s5)
	);

	// Stage 5: add the delta to the weight with saturation, write back.
	logic signed [VAL_W:0] wsum;
	logic                  wclamp;
	val_t                  wsat;
	logic                  upd_s5;
	logic                  skip_fin, sat_fin;

	always_comb begin
		wsum   = (VAL_W+1)'(old_w_s5) + (VAL_W+1)'(delta_s5);
		wclamp = 1'b0;
		if (wsum > W_MAX) begin
			wsat   = val_t'(W_MAX);
			wclamp = 1'b1;
		end else if (wsum < W_MIN) begin
			wsat   = val_t'(W_MIN);
			wclamp = 1'b1;
		end else begin
			wsat = val_t'(wsum);
		end
		upd_s5    = (ctl_s5.op == OP_UPD);
		w_fin     = upd_s5 ? wsat : old_w_s5;
		d_fin     = upd_s5 ? delta_s5 : old_d_s5;
		sat_fin   = upd_s5 && (dsat_s5 || wclamp);
		skip_fin  = (ctl_s5.op == OP_HOLD) || (ctl_s5.op == OP_NONE);
		ram_we    = ctl_s5.valid && (ctl_s5.op == OP_LOAD || upd_s5);
		ram_wdata = {w_fin, d_fin};
	end

	// Control flow: valid bits and the result strobe.
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= '{valid: accept, op: op_in};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			done_q <= ctl_s5.valid;
		end
	end

	// Payload registers.
	val_t w_out_q, d_out_q;
	logic skip_q, sat_q;

	always_ff @(posedge clk) begin
		slot_s1  <= slot;
		act_s1   <= activation;
		grad_s1  <= gradient;
		load_s1  <= load_value;

		slot_s2  <= slot_s1;
		act_s2   <= act_s1;
		gclip_s2 <= gclip_c;
		old_w_s2 <= old_w_c;
		old_d_s2 <= old_d_c;

		slot_s3  <= slot_s2;
		old_w_s3 <= old_w_s2;
		old_d_s3 <= old_d_s2;

		slot_s4  <= slot_s3;
		old_w_s4 <= old_w_s3;
		old_d_s4 <= old_d_s3;

		slot_s5  <= slot_s4;
		old_w_s5 <= old_w_s4;
		old_d_s5 <= old_d_s4;

		w_out_q  <= w_fin;
		d_out_q  <= d_fin;
		skip_q   <= skip_fin;
		sat_q    <= sat_fin;
	end

	assign done       = done_q;
	assign new_weight = w_out_q;
	assign new_delta  = d_out_q;
	assign skipped    = skip_q;
	assign saturated  = sat_q;

	// Every accepted word gives its result through the result strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("result strobe missing six cycles after acceptance");

	// A write-back never has a second write to the same slot behind it.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(writes_slot(ctl_s1, slot_s1, slot_s5) ||
		             writes_slot(ctl_s2, slot_s2, slot_s5) ||
		             writes_slot(ctl_s3, slot_s3, slot_s5) ||
		             writes_slot(ctl_s4, slot_s4, slot_s5)))
		else $error("two writes to one slot in flight");

	// A skipped slot was not computed, so it cannot report saturation.
	a_skip_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(skipped && saturated))
		else $error("skipped result flagged as saturated");

endmodule
